// ===== hdl/step_dir_position_generator_macros.svh =====
// Assertion macros used by the step/direction generator top level.
`ifndef STEP_DIR_POSITION_GENERATOR_MACROS_SVH
`define STEP_DIR_POSITION_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SDPG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SDPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sdpg_pkg.sv =====
// Types and constants for the step/direction position generator.
package sdpg_pkg;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_TARGET = 2'd1,
    REQ_SPEED  = 2'd2,
    REQ_RESET  = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t          req_type;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               step_level;
    logic               dir_level;
    logic signed [31:0] position;
    logic [23:0]        period;
    logic               running;
  } res_t;

  localparam int unsigned DEFAULT_PERIOD = 2000;

endpackage

// ===== hdl/sdpg_core.sv =====
// Step timer, direction and position state with its single-pass update.
module sdpg_core import sdpg_pkg::*; #(
  parameter int PERIOD_BITS = 24,
  parameter int RUN_AHEAD   = 1000
) (
  input  logic clk,
  input  logic rst,
  input  logic speed_mode,
  input  logic accept,
  input  req_t req,
  output res_t result
);

  localparam logic [31:0] PERIOD_MAX = 32'hFFFF_FFFF >> (32 - PERIOD_BITS);
  localparam logic [31:0] AHEAD      = 32'(RUN_AHEAD);

  logic [31:0]            position_count, position_count_next;
  logic [31:0]            target_position;
  logic [PERIOD_BITS-1:0] step_period, step_period_next;
  logic [PERIOD_BITS-1:0] tick_count, tick_count_next;
  logic                   step_line, step_line_next;
  logic                   dir_line, dir_line_next;
  logic                   timer_on, timer_on_next;
  logic                   speed_negative, speed_negative_next;

  logic [31:0]            value_u;
  logic [31:0]            mag;
  logic [31:0]            mag_sat;
  logic [PERIOD_BITS-1:0] period_cand;
  logic [PERIOD_BITS-1:0] tick_inc;
  logic [31:0]            pos_a;
  logic [31:0]            tgt_a;
  logic [31:0]            tgt_b;
  logic                   up;

  assign value_u     = 32'(req.value);
  assign mag         = value_u[31] ? (32'd0 - value_u) : value_u;
  assign mag_sat     = (mag > PERIOD_MAX) ? PERIOD_MAX : mag;
  assign period_cand = mag_sat[PERIOD_BITS-1:0];
  assign tick_inc    = tick_count + PERIOD_BITS'(1);

  always_comb begin
    pos_a               = position_count;
    tgt_a               = target_position;
    step_period_next    = step_period;
    timer_on_next       = timer_on;
    speed_negative_next = speed_negative;
    case (req.req_type)
      REQ_TARGET: begin
        tgt_a = value_u;
      end
      REQ_SPEED: begin
        speed_negative_next = value_u[31];
        if (period_cand != step_period) begin
          step_period_next = period_cand;
          timer_on_next    = |period_cand;
        end
      end
      REQ_RESET: begin
        pos_a = '0;
        tgt_a = '0;
      end
      default: begin
      end
    endcase

    if (speed_mode) begin
      tgt_b = speed_negative_next ? (pos_a - AHEAD) : (pos_a + AHEAD);
    end else begin
      tgt_b = tgt_a;
    end

    up                  = $signed(tgt_b) > $signed(pos_a);
    tick_count_next     = tick_count;
    step_line_next      = step_line;
    dir_line_next       = dir_line;
    position_count_next = pos_a;
    if (req.req_type == REQ_TICK && timer_on) begin
      tick_count_next = tick_inc;
      if (tick_inc >= step_period) begin
        tick_count_next = '0;
        dir_line_next   = up;
        if (tgt_b != pos_a) begin
          step_line_next = ~step_line;
          if (!step_line) begin
            position_count_next = up ? (pos_a + 32'd1) : (pos_a - 32'd1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count  <= '0;
      target_position <= '0;
      step_period     <= PERIOD_BITS'(DEFAULT_PERIOD);
      tick_count      <= '0;
      step_line       <= 1'b0;
      dir_line        <= 1'b1;
      timer_on        <= 1'b1;
      speed_negative  <= 1'b0;
    end else if (accept) begin
      position_count  <= position_count_next;
      target_position <= tgt_b;
      step_period     <= step_period_next;
      tick_count      <= tick_count_next;
      step_line       <= step_line_next;
      dir_line        <= dir_line_next;
      timer_on        <= timer_on_next;
      speed_negative  <= speed_negative_next;
    end
  end

  always_comb begin
    result.step_level = step_line_next;
    result.dir_level  = dir_line_next;
    result.position   = $signed(position_count_next);
    result.period     = 24'(step_period_next);
    result.running    = timer_on_next;
  end

endmodule

// ===== hdl/step_dir_position_generator.sv =====
// Top level of the step/direction position generator with output skid buffer.
//
//   channel | handshake              | word
//   --------+------------------------+-----------------------------
//   cfg     | cfg_valid / cfg_ready  | cfg_data (speed_mode)
//   req     | req_valid / req_stall  | req (req_type, value)
//   res     | res_valid / res_stall  | res (step, dir, position, period, running)
//
// One word in, one word out; a request word is taken every cycle while
// req_stall is low, and its result is registered in the output register.
// A skid register holds one result while res is stalled; req_stall rises only
// when both output and skid registers are full. cfg_ready is always high.
// Synchronous reset restores position 0, period 2000 and a running timer.
module step_dir_position_generator import sdpg_pkg::*; #(
  parameter int PERIOD_BITS = 24,
  parameter int RUN_AHEAD   = 1000
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  logic speed_mode;
  logic accept;
  logic out_fire;
  logic skid_valid;
  res_t skid;
  res_t result;

  assign cfg_ready = 1'b1;
  assign req_stall = skid_valid;
  assign accept    = req_valid && !skid_valid;
  assign out_fire  = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      speed_mode <= cfg_data;
    end
  end

  sdpg_core #(
    .PERIOD_BITS (PERIOD_BITS),
    .RUN_AHEAD   (RUN_AHEAD)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .speed_mode (speed_mode),
    .accept     (accept),
    .req        (req),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || out_fire) begin
      res_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || out_fire) begin
      if (skid_valid) begin
        res <= skid;
      end else if (accept) begin
        res <= result;
      end
    end else if (accept) begin
      skid <= result;
    end
  end

  `include "step_dir_position_generator_macros.svh"

  `SDPG_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, res_valid, "skid full with empty output")
  `SDPG_ASSERT_NEXT(a_skid_fill, clk, rst, res_valid && res_stall && accept, skid_valid, "stalled word not held in skid")
  `SDPG_ASSERT_NEXT(a_out_drain, clk, rst, out_fire && !skid_valid && !accept, !res_valid, "output valid without a word")

endmodule
